>>> design/slh_pkg.sv
// ============================================================================
// slh_pkg
// Shared types and constants of the single-lane 64-bit hash block.
// ============================================================================
`default_nettype none

package slh_pkg;

    // Mixing primes.
    localparam logic [63:0] HP1 = 64'h9e3779b185ebca87;
    localparam logic [63:0] HP2 = 64'hc2b2ae3d27d4eb4f;
    localparam logic [63:0] HP3 = 64'h165667b19e3779f9;
    localparam logic [63:0] HP4 = 64'h85ebca77c2b2ae63;
    localparam logic [63:0] HP5 = 64'h27d4eb2f165667c5;

    // Rotate and shift amounts.
    localparam int ROT_ROUND = 27;
    localparam int ROT_TAIL  = 11;
    localparam int SHIFT_AV1 = 33;
    localparam int SHIFT_AV2 = 29;
    localparam int SHIFT_AV3 = 32;

    // Commands from the controller to the datapath, one per cycle.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_SET_ROUND,
        CMD_SET_BYTE,
        CMD_SET_TAIL,
        CMD_SET_AVAL1,
        CMD_SET_AVAL2,
        CMD_MUL0,
        CMD_MUL1,
        CMD_MUL2,
        CMD_ACC_ROUND,
        CMD_ACC_TAIL,
        CMD_EMIT
    } slh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic tail_left;
        logic last;
        logic out_busy;
    } slh_status_t;

endpackage

`default_nettype wire

>>> design/slh_if.sv
// ============================================================================
// slh_in_if / slh_out_if
// Valid/ready channels for message words and for hash results.
// ============================================================================
`default_nettype none

interface slh_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_data;
    logic [3:0]  byte_count;
    logic        start_flag;
    logic [31:0] message_length;
    logic        end_of_message;

    modport source (
        output valid, word_data, byte_count, start_flag, message_length, end_of_message,
        input  ready
    );
    modport sink (
        input  valid, word_data, byte_count, start_flag, message_length, end_of_message,
        output ready
    );
endinterface

interface slh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

`default_nettype wire

>>> design/slh_datapath.sv
// ============================================================================
// slh_datapath
// Accumulator, word buffer, shared 32x32 multiplier and result register.
// ============================================================================
`default_nettype none

module slh_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic [63:0]         word_data,
    input  wire logic [3:0]          byte_count,
    input  wire logic                start_flag,
    input  wire logic [31:0]         message_length,
    input  wire logic                end_of_message,
    input  wire slh_pkg::slh_cmd_t   cmd,
    output slh_pkg::slh_status_t     status,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [63:0]              hash_value
);
    import slh_pkg::*;

    typedef enum logic [1:0] {CS_P1, CS_P2, CS_P3, CS_P5} csel_t;

    localparam logic [63:0] START_BASE = HP5 + 64'd1;

    // Control state, cleared by reset.
    logic [63:0] acc_reg,       acc_next;
    logic [3:0]  cnt_reg,       cnt_next;
    logic [2:0]  idx_reg,       idx_next;
    logic        last_reg,      last_next;
    logic        out_valid_reg, out_valid_next;

    // Payload registers.
    logic [63:0] word_reg, word_next;
    logic [63:0] mop_reg,  mop_next;
    csel_t       csel_reg, csel_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] hash_reg, hash_next;

    logic [63:0] mul_const;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;
    logic [7:0]  tail_byte;
    logic [63:0] round_in;
    logic [63:0] round_rot;
    logic [63:0] tail_in;
    logic [63:0] tail_rot;

    always_comb
    begin
        unique case (csel_reg)
            CS_P1:   mul_const = HP1;
            CS_P2:   mul_const = HP2;
            CS_P3:   mul_const = HP3;
            CS_P5:   mul_const = HP5;
            default: mul_const = HP1;
        endcase
    end

    // A 64-bit product modulo 2^64 takes three passes: low x low, then the
    // two cross terms folded into the upper half.
    assign mul_x = (cmd == CMD_MUL2) ? mop_reg[63:32] : mop_reg[31:0];
    assign mul_y = (cmd == CMD_MUL1) ? mul_const[63:32] : mul_const[31:0];
    assign mul_p = {32'h0, mul_x} * {32'h0, mul_y};

    assign tail_byte = word_reg[{~idx_reg, 3'b000} +: 8];
    assign round_in  = acc_reg ^ word_reg;
    assign round_rot = (round_in << ROT_ROUND) | (round_in >> (64 - ROT_ROUND));
    assign tail_in   = acc_reg ^ prod_reg;
    assign tail_rot  = (tail_in << ROT_TAIL) | (tail_in >> (64 - ROT_TAIL));

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        mop_next       = mop_reg;
        csel_next      = csel_reg;
        prod_next      = prod_reg;
        hash_next      = hash_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            word_next = word_data;
            cnt_next  = byte_count[3] ? 4'd8 : byte_count;
            idx_next  = '0;
            last_next = end_of_message;
            if (start_flag)
            begin
                acc_next = START_BASE + {32'h0, message_length};
            end
        end

        unique case (cmd)
            CMD_SET_ROUND:
            begin
                mop_next  = round_rot;
                csel_next = CS_P1;
            end
            CMD_SET_BYTE:
            begin
                mop_next  = {56'h0, tail_byte};
                csel_next = CS_P5;
            end
            CMD_SET_TAIL:
            begin
                mop_next  = tail_rot;
                csel_next = CS_P1;
            end
            CMD_SET_AVAL1:
            begin
                mop_next  = acc_reg ^ (acc_reg >> SHIFT_AV1);
                csel_next = CS_P2;
            end
            CMD_SET_AVAL2:
            begin
                mop_next  = prod_reg ^ (prod_reg >> SHIFT_AV2);
                csel_next = CS_P3;
            end
            CMD_MUL0:
            begin
                prod_next = mul_p;
            end
            CMD_MUL1, CMD_MUL2:
            begin
                prod_next = {prod_reg[63:32] + mul_p[31:0], prod_reg[31:0]};
            end
            CMD_ACC_ROUND:
            begin
                acc_next = prod_reg + HP4;
                cnt_next = '0;
            end
            CMD_ACC_TAIL:
            begin
                acc_next = prod_reg;
                idx_next = idx_reg + 3'd1;
            end
            CMD_EMIT:
            begin
                hash_next      = prod_reg ^ (prod_reg >> SHIFT_AV3);
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        mop_reg  <= mop_next;
        csel_reg <= csel_next;
        prod_reg <= prod_next;
        hash_reg <= hash_next;
    end

    assign status.full      = cnt_reg[3];
    assign status.tail_left = ({1'b0, idx_reg} != cnt_reg);
    assign status.last      = last_reg;
    assign status.out_busy  = out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

`default_nettype wire

>>> design/slh_ctrl.sv
// ============================================================================
// slh_ctrl
// Sequencer that walks one item through rounds, tail steps and avalanche.
// ============================================================================
`default_nettype none

module slh_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire slh_pkg::slh_status_t status,
    output logic                      ready,
    output slh_pkg::slh_cmd_t         cmd
);
    import slh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_POST,
        S_SETTLE
    } state_t;

    typedef enum logic [2:0] {
        J_ROUND,
        J_BYTE,
        J_TAIL,
        J_AVAL1,
        J_AVAL2
    } job_t;

    state_t   state_reg, state_next;
    job_t     job_reg,   job_next;
    logic     ready_reg, ready_next;
    slh_cmd_t cmd_reg,   cmd_next;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        ready_next = ready_reg;
        cmd_next   = CMD_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    ready_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.full)
                begin
                    cmd_next   = CMD_SET_ROUND;
                    job_next   = J_ROUND;
                    state_next = S_MUL0;
                end
                else if (status.tail_left)
                begin
                    cmd_next   = CMD_SET_BYTE;
                    job_next   = J_BYTE;
                    state_next = S_MUL0;
                end
                else if (status.last)
                begin
                    cmd_next   = CMD_SET_AVAL1;
                    job_next   = J_AVAL1;
                    state_next = S_MUL0;
                end
                else
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MUL0:
            begin
                cmd_next   = CMD_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd_next   = CMD_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd_next   = CMD_MUL2;
                state_next = S_POST;
            end
            S_POST:
            begin
                unique case (job_reg)
                    J_ROUND:
                    begin
                        cmd_next   = CMD_ACC_ROUND;
                        state_next = S_SETTLE;
                    end
                    J_BYTE:
                    begin
                        cmd_next   = CMD_SET_TAIL;
                        job_next   = J_TAIL;
                        state_next = S_MUL0;
                    end
                    J_TAIL:
                    begin
                        cmd_next   = CMD_ACC_TAIL;
                        state_next = S_SETTLE;
                    end
                    J_AVAL1:
                    begin
                        cmd_next   = CMD_SET_AVAL2;
                        job_next   = J_AVAL2;
                        state_next = S_MUL0;
                    end
                    J_AVAL2:
                    begin
                        if (!status.out_busy)
                        begin
                            cmd_next   = CMD_EMIT;
                            ready_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_SETTLE;
                    end
                endcase
            end
            S_SETTLE:
            begin
                state_next = S_DECIDE;
            end
            default:
            begin
                state_next = S_SETTLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SETTLE;
            job_reg   <= J_ROUND;
            ready_reg <= 1'b0;
            cmd_reg   <= CMD_NONE;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            ready_reg <= ready_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign ready = ready_reg;
    assign cmd   = cmd_reg;

endmodule

`default_nettype wire

>>> design/single_lane_hash64.sv
// ============================================================================
// single_lane_hash64
// Single-lane 64-bit streaming hash over big-endian message words.
// ============================================================================
// Items are taken one at a time. A sequencer (slh_ctrl) drives a datapath
// (slh_datapath) that owns the accumulator and one 32x32 multiplier; every
// 64-bit product modulo 2^64 is built from three passes through that
// multiplier, and this shared multiplier sets the item time. A full
// eight-byte item runs one round, a short item runs a byte step and a tail
// step per tail byte, and a final item then runs the avalanche; an item
// with no data bytes that is not final only passes the decide state. A
// final item also waits, before handing over its hash, until the previous
// hash has left the output register. While a hash sits in that register
// the block goes on accepting and hashing new items. A start item reloads
// the accumulator from the message length before its data is mixed in;
// counts above eight are treated as eight, and bytes beyond the count are
// ignored. After reset the sequencer passes its settle and decide states
// before it first raises ready.
// ============================================================================
`default_nettype none

module single_lane_hash64 (
    input  wire logic clk,
    input  wire logic rst_n,
    slh_in_if.sink    item_in,
    slh_out_if.source hash_out
);
    import slh_pkg::*;

    logic        ctrl_ready;
    logic        load;
    slh_cmd_t    cmd;
    slh_status_t status;

    // An item is taken whenever the sequencer is idle and the source offers.
    assign load          = item_in.valid & ctrl_ready;
    assign item_in.ready = ctrl_ready;

    slh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .status (status),
        .ready  (ctrl_ready),
        .cmd    (cmd)
    );

    slh_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .word_data      (item_in.word_data),
        .byte_count     (item_in.byte_count),
        .start_flag     (item_in.start_flag),
        .message_length (item_in.message_length),
        .end_of_message (item_in.end_of_message),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (hash_out.valid),
        .out_ready      (hash_out.ready),
        .hash_value     (hash_out.hash_value)
    );

endmodule

`default_nettype wire

>>> design/slh_checker.sv
// ============================================================================
// slh_checker
// Port-level checks of the hash block, bound to its top level.
// ============================================================================
`default_nettype none

module slh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] hash_value
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_value))
        else $error("stalled hash changed or dropped");

    // Items are worked one at a time, so ready drops after each accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after an accepted item");

    // A hash appears only at the end of work, when ready was low.
    a_emit_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready, 2))
        else $error("hash appeared without preceding work");

    // Results are far apart; a taken hash is never followed at once by another.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("two hashes in consecutive cycles");

endmodule

bind single_lane_hash64 slh_checker u_slh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item_in.valid),
    .in_ready   (item_in.ready),
    .out_valid  (hash_out.valid),
    .out_ready  (hash_out.ready),
    .hash_value (hash_out.hash_value)
);

`default_nettype wire
